### hdl/rgfa_pkg.sv
`timescale 1ns / 1ps
package rgfa_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 16;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int DIM_W       = 5;
  localparam int POS_W       = 8;
  localparam int REQ_W       = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [REQ_W-1:0] REQ_FIND  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TEST  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  typedef logic [MAX_COLUMNS-1:0] row_bits_t;

  typedef struct packed {
    logic             wr_en;
    logic             set_bits;
    logic             clr_all;
    logic [ROW_W-1:0] addr;
    row_bits_t        mask;
  } store_cmd_t;

  function automatic row_bits_t span_mask(input logic [COL_W-1:0] col,
                                          input logic [DIM_W-1:0] n);
    logic [MAX_COLUMNS:0] ones;
    ones = ({{MAX_COLUMNS{1'b0}}, 1'b1} << n) - {{MAX_COLUMNS{1'b0}}, 1'b1};
    return ones[MAX_COLUMNS-1:0] << col;
  endfunction

endpackage

### hdl/rgfa_store.sv
`timescale 1ns / 1ps
module rgfa_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rgfa_pkg::store_cmd_t          cmd,
  input  logic [rgfa_pkg::ROW_W-1:0]    raddr,
  output rgfa_pkg::row_bits_t           rdata
);

  rgfa_pkg::row_bits_t rows_r [rgfa_pkg::MAX_ROWS];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) begin
      for (int i = 0; i < rgfa_pkg::MAX_ROWS; i++) begin
        rows_r[i] <= '0;
      end
    end else if (cmd.wr_en) begin
      if (cmd.set_bits) begin
        rows_r[cmd.addr] <= rows_r[cmd.addr] | cmd.mask;
      end else begin
        rows_r[cmd.addr] <= rows_r[cmd.addr] & ~cmd.mask;
      end
    end
  end

  assign rdata = rows_r[raddr];

endmodule

### hdl/rgfa_win.sv
`timescale 1ns / 1ps
module rgfa_win (
  input  rgfa_pkg::row_bits_t           occ_or,
  input  logic [rgfa_pkg::DIM_W-1:0]    grid_w,
  input  logic [rgfa_pkg::DIM_W-1:0]    item_w,
  output logic                          hit,
  output logic [rgfa_pkg::COL_W-1:0]    col
);

  // first free window in a merged row band, lowest column wins
  always_comb begin
    logic [rgfa_pkg::DIM_W:0] span_end;
    logic                     fits;
    hit = 1'b0;
    col = '0;
    for (int c = rgfa_pkg::MAX_COLUMNS - 1; c >= 0; c--) begin
      span_end = (rgfa_pkg::DIM_W + 1)'(c) + {1'b0, item_w};
      fits = (span_end <= {1'b0, grid_w}) &&
             ((occ_or & rgfa_pkg::span_mask(rgfa_pkg::COL_W'(c), item_w)) == '0);
      if (fits) begin
        hit = 1'b1;
        col = rgfa_pkg::COL_W'(c);
      end
    end
  end

endmodule

### hdl/rect_grid_first_fit_allocator_core.sv
`timescale 1ns / 1ps
// First-fit rectangle allocator over a grid of up to 16 by 16 cells, one
// request in, one result out. Timing is set by the single row read port of
// the occupancy store and the subtract unit that turns position into row and
// column: every request first divides by repeated subtraction, then find
// reads h rows per candidate top row and then searches the columns of the
// merged band; put and test read h rows, put then writes h rows; free writes
// its clipped height; clear wipes every row of the store in one write.
// A result waits in an output register; the next item is taken once the
// current one is finished.
module rect_grid_first_fit_allocator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,  // position, item_width, item_height
  input  logic [rgfa_pkg::REQ_W-1:0]        in_tuser,  // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata, // found_position
  output logic                              out_tuser, // success
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgfa_pkg::DIM_W-1:0]        cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_EVAL = 7'b0010000,
    S_WR   = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  localparam int DW = rgfa_pkg::DIM_W;
  localparam int PW = rgfa_pkg::POS_W;
  localparam int RW = rgfa_pkg::ROW_W;
  localparam int CW = rgfa_pkg::COL_W;

  state_t                     state_r, state_nxt;
  logic [DW-1:0]              cfg_w_r, cfg_h_r;
  logic [rgfa_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [PW-1:0]              rem_r, rem_nxt;
  logic [RW-1:0]              row_r, row_nxt;
  logic                       pos_ok_r, pos_ok_nxt;
  logic [DW-1:0]              iw_r, iw_nxt, ih_r, ih_nxt;
  logic [RW-1:0]              base_r, base_nxt;
  logic [DW-1:0]              y_r, y_nxt, cnt_r, cnt_nxt;
  rgfa_pkg::row_bits_t        orv_r, orv_nxt, mask_r, mask_nxt;
  logic [PW-1:0]              idx_base_r, idx_base_nxt;
  logic                       ok_r, ok_nxt;
  logic [PW-1:0]              found_r, found_nxt;
  logic                       out_valid_r;
  logic                       out_succ_r;
  logic [PW-1:0]              out_pos_r;

  logic [DW-1:0]              grid_w, grid_h;
  logic [CW-1:0]              col;
  logic                       win_hit;
  logic [CW-1:0]              win_col;
  rgfa_pkg::row_bits_t        rd_data;
  rgfa_pkg::row_bits_t        rect_mask;
  rgfa_pkg::store_cmd_t       cmd;
  logic [RW-1:0]              cur_row;
  logic [DW:0]                row_end, col_end, next_end;
  logic [DW-1:0]              clip_w, clip_h;
  logic                       dims_ok, size_ok;

  assign grid_w = (cfg_w_r > DW'(rgfa_pkg::MAX_COLUMNS)) ?
                  DW'(rgfa_pkg::MAX_COLUMNS) : cfg_w_r;
  assign grid_h = (cfg_h_r > DW'(rgfa_pkg::MAX_ROWS)) ?
                  DW'(rgfa_pkg::MAX_ROWS) : cfg_h_r;

  assign dims_ok  = (grid_w != '0) && (grid_h != '0);
  assign size_ok  = (iw_r != '0) && (ih_r != '0);
  assign col      = rem_r[CW-1:0];
  assign cur_row  = base_r + y_r[RW-1:0];
  assign row_end  = {{(DW + 1 - RW){1'b0}}, row_r} + {1'b0, ih_r};
  assign col_end  = {{(DW + 1 - CW){1'b0}}, col} + {1'b0, iw_r};
  assign next_end = {{(DW + 1 - RW){1'b0}}, base_r} + {1'b0, ih_r} + (DW + 1)'(1);
  assign clip_w   = (col_end > {1'b0, grid_w}) ? (grid_w - {{(DW - CW){1'b0}}, col}) : iw_r;
  assign clip_h   = (row_end > {1'b0, grid_h}) ? (grid_h - {{(DW - RW){1'b0}}, row_r}) : ih_r;
  assign rect_mask = rgfa_pkg::span_mask(col, iw_r);

  rgfa_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .raddr (cur_row),
    .rdata (rd_data)
  );

  rgfa_win u_win (
    .occ_or (orv_r),
    .grid_w (grid_w),
    .item_w (iw_r),
    .hit    (win_hit),
    .col    (win_col)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_succ_r;
  assign out_tdata  = out_pos_r;

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    rem_nxt      = rem_r;
    row_nxt      = row_r;
    pos_ok_nxt   = pos_ok_r;
    iw_nxt       = iw_r;
    ih_nxt       = ih_r;
    base_nxt     = base_r;
    y_nxt        = y_r;
    cnt_nxt      = cnt_r;
    orv_nxt      = orv_r;
    mask_nxt     = mask_r;
    idx_base_nxt = idx_base_r;
    ok_nxt       = ok_r;
    found_nxt    = found_r;
    cmd          = '0;
    cmd.addr     = cur_row;
    cmd.mask     = mask_r;
    cmd.set_bits = (req_r == rgfa_pkg::REQ_PUT);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt    = in_tuser;
          rem_nxt    = in_tdata[7:0];
          iw_nxt     = in_tdata[12:8];
          ih_nxt     = in_tdata[17:13];
          row_nxt    = '0;
          pos_ok_nxt = 1'b0;
          ok_nxt     = 1'b0;
          found_nxt  = '0;
          state_nxt  = S_DIV;
        end
      end

      // position to row and column by repeated subtraction
      S_DIV: begin
        if (!dims_ok) begin
          pos_ok_nxt = 1'b0;
          state_nxt  = S_CHK;
        end else if (rem_r >= {{(PW - DW){1'b0}}, grid_w}) begin
          if (({1'b0, row_r} + (RW + 1)'(1)) == (RW + 1)'(grid_h)) begin
            pos_ok_nxt = 1'b0;
            state_nxt  = S_CHK;
          end else begin
            rem_nxt = rem_r - {{(PW - DW){1'b0}}, grid_w};
            row_nxt = row_r + RW'(1);
          end
        end else begin
          pos_ok_nxt = 1'b1;
          state_nxt  = S_CHK;
        end
      end

      S_CHK: begin
        y_nxt     = '0;
        orv_nxt   = '0;
        state_nxt = S_DONE;
        case (req_r)
          rgfa_pkg::REQ_FIND: begin
            if (dims_ok && size_ok && iw_r <= grid_w && ih_r <= grid_h) begin
              base_nxt     = '0;
              idx_base_nxt = '0;
              state_nxt    = S_ACC;
            end
          end
          rgfa_pkg::REQ_PUT, rgfa_pkg::REQ_TEST: begin
            if (pos_ok_r && size_ok && row_end <= {1'b0, grid_h} &&
                col_end <= {1'b0, grid_w}) begin
              base_nxt  = row_r;
              state_nxt = S_ACC;
            end
          end
          rgfa_pkg::REQ_FREE: begin
            if (pos_ok_r && size_ok) begin
              base_nxt  = row_r;
              mask_nxt  = rgfa_pkg::span_mask(col, clip_w);
              cnt_nxt   = clip_h;
              state_nxt = S_WR;
            end
          end
          rgfa_pkg::REQ_CLEAR: begin
            cmd.clr_all = 1'b1;
            ok_nxt      = dims_ok;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end

      // merge the rows of the band under the rectangle
      S_ACC: begin
        orv_nxt = orv_r | rd_data;
        y_nxt   = y_r + DW'(1);
        if ((y_r + DW'(1)) == ih_r) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        y_nxt   = '0;
        orv_nxt = '0;
        if (req_r == rgfa_pkg::REQ_FIND) begin
          if (win_hit) begin
            ok_nxt    = 1'b1;
            found_nxt = idx_base_r + {{(PW - CW){1'b0}}, win_col};
            state_nxt = S_DONE;
          end else if (next_end <= {1'b0, grid_h}) begin
            base_nxt     = base_r + RW'(1);
            idx_base_nxt = idx_base_r + {{(PW - DW){1'b0}}, grid_w};
            state_nxt    = S_ACC;
          end else begin
            state_nxt = S_DONE;
          end
        end else if ((orv_r & rect_mask) != '0) begin
          state_nxt = S_DONE;
        end else if (req_r == rgfa_pkg::REQ_PUT) begin
          mask_nxt  = rect_mask;
          cnt_nxt   = ih_r;
          state_nxt = S_WR;
        end else begin
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_WR: begin
        cmd.wr_en = 1'b1;
        y_nxt     = y_r + DW'(1);
        if ((y_r + DW'(1)) == cnt_r) begin
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_w_r     <= DW'(16);
      cfg_h_r     <= DW'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rgfa_pkg::REG_GRID_WIDTH:  cfg_w_r <= cfg_data;
          rgfa_pkg::REG_GRID_HEIGHT: cfg_h_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rem_r      <= rem_nxt;
    row_r      <= row_nxt;
    pos_ok_r   <= pos_ok_nxt;
    iw_r       <= iw_nxt;
    ih_r       <= ih_nxt;
    base_r     <= base_nxt;
    y_r        <= y_nxt;
    cnt_r      <= cnt_nxt;
    orv_r      <= orv_nxt;
    mask_r     <= mask_nxt;
    idx_base_r <= idx_base_nxt;
    ok_r       <= ok_nxt;
    found_r    <= found_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_succ_r <= ok_r;
      out_pos_r  <= found_r;
    end
  end

endmodule

### bench/alloc_checker.sv
`timescale 1ns / 1ps
module alloc_checker
  import rgfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [23:0]          in_tdata,
  input  logic [REQ_W-1:0]     in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,
  input  logic                 out_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic             success;
    logic [POS_W-1:0] position;
  } alloc_result_t;

  alloc_result_t    awaited_results[$];
  alloc_result_t    oldest;
  row_bits_t        occupied [MAX_ROWS];
  logic [DIM_W-1:0] cols_reg;
  logic [DIM_W-1:0] rows_reg;

  function automatic row_bits_t cell_span(input int col, input int n);
    logic [63:0] ones;
    ones = ((64'd1 << n) - 64'd1) << col;
    return ones[MAX_COLUMNS-1:0];
  endfunction

  function automatic bit area_clear(input int row, input int col, input int w, input int h,
                                    input int gw, input int gh);
    row_bits_t m;
    int        y;
    if (w == 0 || h == 0 || gw == 0 || gh == 0) return 1'b0;
    if (row + h > gh || col + w > gw) return 1'b0;
    m = cell_span(col, w);
    for (y = 0; y < h; y++)
      if ((occupied[row + y] & m) != '0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic alloc_result_t serve_request(input logic [REQ_W-1:0] req,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DIM_W-1:0] iw,
                                                  input logic [DIM_W-1:0] ih);
    alloc_result_t res;
    row_bits_t     m;
    int            gw, gh, row, col, cw, rh, r, c, y, idx, p, w, h;
    bit            pos_ok;
    res = '0;
    gw = (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
    gh = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    p = int'(pos);
    w = int'(iw);
    h = int'(ih);
    row = 0;
    col = 0;
    pos_ok = 1'b0;
    if (gw != 0 && gh != 0 && p < gw * gh) begin
      pos_ok = 1'b1;
      row = p / gw;
      col = p % gw;
    end
    case (req)
      REQ_FIND: begin
        if (gw != 0 && gh != 0 && w != 0 && h != 0 && w <= gw && h <= gh) begin
          for (r = 0; r < gh && !res.success; r++)
            for (c = 0; c < gw && !res.success; c++) begin
              idx = r * gw + c;
              if (idx > 255) break;
              if (area_clear(r, c, w, h, gw, gh)) begin
                res.success = 1'b1;
                res.position = idx[POS_W-1:0];
              end
            end
        end
      end
      REQ_PUT: begin
        if (pos_ok && area_clear(row, col, w, h, gw, gh)) begin
          m = cell_span(col, w);
          for (y = 0; y < h; y++) occupied[row + y] |= m;
          res.success = 1'b1;
        end
      end
      REQ_FREE: begin
        if (pos_ok && w != 0 && h != 0) begin
          cw = (col + w > gw) ? gw - col : w;
          rh = (row + h > gh) ? gh - row : h;
          m = cell_span(col, cw);
          for (y = 0; y < rh; y++) occupied[row + y] &= ~m;
          res.success = 1'b1;
        end
      end
      REQ_TEST: begin
        if (pos_ok && area_clear(row, col, w, h, gw, gh)) res.success = 1'b1;
      end
      REQ_CLEAR: begin
        for (y = 0; y < MAX_ROWS; y++) occupied[y] = '0;
        res.success = (gw != 0 && gh != 0);
      end
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < MAX_ROWS; y++) occupied[y] = '0;
      cols_reg = DIM_W'(MAX_COLUMNS);
      rows_reg = DIM_W'(MAX_ROWS);
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH:  cols_reg = cfg_data;
          REG_GRID_HEIGHT: rows_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no request outstanding: success %0d, found_position %0d",
                 out_tuser, out_tdata);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_tuser !== oldest.success) begin
            $error("success: expected %0d, got %0d", oldest.success, out_tuser);
            mismatches++;
          end
          if (out_tdata !== oldest.position) begin
            $error("found_position: expected %0d, got %0d", oldest.position, out_tdata);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(serve_request(in_tuser, in_tdata[7:0], in_tdata[12:8],
                                                in_tdata[17:13]));
    end
    pending = awaited_results.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rgfa_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RESERVED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RESERVED_HI = 3'd7;
  localparam int IDLE_PERCENT   = 6;
  localparam int STALL_CYCLES   = 400;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int PHASES         = 9;
  localparam int FIXED_PHASES   = 7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // position, item_width, item_height
  logic [REQ_W-1:0]     in_tuser;   // req_type
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // found_position
  logic                 out_tuser;  // success
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  int mismatches;
  int pending;
  int quiet_cycles;
  bit quiet_run;
  bit hold_output;

  int phase_cols [FIXED_PHASES] = '{16, 16, 6, 31, 12, 1, 16};
  int phase_rows [FIXED_PHASES] = '{16, 16, 4, 31, 16, 16, 1};

  rect_grid_first_fit_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  alloc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_tready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      out_tready = quiet_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int clamp_dim(input int raw, input int limit);
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic logic [DIM_W-1:0] pick_size(input int limit);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 15)
      return DIM_W'($urandom_range(1, (limit < 1) ? 1 : ((limit > 4) ? 4 : limit)));
    else if (roll < 18) return DIM_W'($urandom_range(0, limit + 1));
    else return DIM_W'($urandom_range(0, 31));
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                              input logic [DIM_W-1:0] iw, input logic [DIM_W-1:0] ih);
    while (!quiet_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = req;
    in_tdata = {6'd0, ih, iw, pos};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_grid(input int cols, input int rows);
    wait_drained();
    write_reg(REG_GRID_WIDTH, cols[DIM_W-1:0]);
    write_reg(REG_GRID_HEIGHT, rows[DIM_W-1:0]);
  endtask

  task automatic random_request(input int gw, input int gh);
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    int               pick;
    int               cells;
    cells = gw * gh;
    pick = $urandom_range(0, 99);
    if (pick < 28) req = REQ_FIND;
    else if (pick < 58) req = REQ_PUT;
    else if (pick < 72) req = REQ_FREE;
    else if (pick < 92) req = REQ_TEST;
    else if (pick < 94) req = REQ_CLEAR;
    else req = REQ_W'($urandom);
    if (cells > 0 && $urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, cells - 1));
    else pos = POS_W'($urandom_range(0, 255));
    send_request(req, pos, pick_size(gw), pick_size(gh));
  endtask

  initial begin
    int cols;
    int rows;
    int phase;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_FIND;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    quiet_run = 1'b0;
    hold_output = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    set_grid(16, 16);
    send_request(REQ_FIND, 0, 16, 16);
    send_request(REQ_PUT, 0, 16, 16);
    send_request(REQ_FIND, 0, 1, 1);
    send_request(REQ_TEST, 0, 1, 1);
    // clipped at both edges
    send_request(REQ_FREE, 255, 31, 31);
    send_request(REQ_FIND, 0, 1, 1);
    send_request(REQ_FREE, 17, 31, 31);
    send_request(REQ_FIND, 0, 17, 1);
    send_request(REQ_FIND, 0, 15, 15);
    send_request(REQ_PUT, 0, 0, 1);
    send_request(REQ_TEST, 0, 1, 0);
    send_request(REQ_FREE, 0, 0, 0);
    send_request(REQ_PUT, 31, 2, 1);
    send_request(REQ_TEST, 240, 1, 2);
    send_request(REQ_PUT, 31, 1, 1);
    send_request(REQ_RESERVED_LO, 255, 31, 31);
    send_request(REQ_RESERVED_HI, 170, 21, 10);
    send_request(REQ_CLEAR, 0, 0, 0);
    send_request(REQ_PUT, 0, 16, 1);
    send_request(REQ_FIND, 0, 1, 2);
    set_grid(0, 16);
    send_request(REQ_FIND, 0, 1, 1);
    send_request(REQ_PUT, 0, 1, 1);
    send_request(REQ_CLEAR, 0, 0, 0);
    set_grid(31, 31);
    send_request(REQ_PUT, 255, 1, 1);
    send_request(REQ_FIND, 0, 16, 16);
    // map kept across a resize
    set_grid(5, 3);
    send_request(REQ_TEST, 15, 1, 1);
    send_request(REQ_FIND, 0, 5, 3);
    set_grid(16, 0);
    send_request(REQ_FREE, 0, 1, 1);
    send_request(REQ_CLEAR, 0, 0, 0);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < FIXED_PHASES) begin
        cols = phase_cols[phase];
        rows = phase_rows[phase];
      end else begin
        cols = $urandom_range(0, 31);
        rows = $urandom_range(0, 31);
      end
      set_grid(cols, rows);
      quiet_run = (phase == 1);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (phase == 4 && n == 30) hold_output = 1'b1;
        if (phase == 2 && n == 100) wait_drained();
        random_request(clamp_dim(cols, MAX_COLUMNS), clamp_dim(rows, MAX_ROWS));
      end
    end
    quiet_run = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
hdl/rgfa_pkg.sv
hdl/rgfa_store.sv
hdl/rgfa_win.sv
hdl/rect_grid_first_fit_allocator_core.sv
bench/alloc_checker.sv
bench/testbench.sv
